[rtl/jpfm_pkg.sv]
// package: constants, types and helper functions for the jet parton flavour match
package jpfm_pkg;

  localparam int ETA_W    = 16;
  localparam int PHI_W    = 15;
  localparam int PT_W     = 20;
  localparam int PID_W    = 32;
  localparam int AID_W    = 5;
  localparam int RADIUS_W = 26;
  localparam int DIFF_W   = 17;
  localparam int SQ_W     = 32;
  localparam int DIST_W   = 33;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic signed [DIFF_W-1:0] PI_Q12     = 17'sd12868;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic [PID_W-1:0]         GLUON_ID   = 32'd21;
  localparam logic [RADIUS_W-1:0]      RADIUS_SQ_RESET = 26'd2684355;

  typedef enum logic [0:0] {
    REG_MATCH_RADIUS_SQ = 1'b0
  } reg_index_t;

  typedef enum logic [1:0] {
    FLAV_GLUON   = 2'd0,
    FLAV_LIGHT   = 2'd1,
    FLAV_HEAVY   = 2'd2,
    FLAV_UNKNOWN = 2'd3
  } flavour_t;

  function automatic logic is_parton(input logic [PID_W-1:0] aid);
    return ((aid >= 32'd1) && (aid <= 32'd5)) || (aid == GLUON_ID);
  endfunction

  function automatic flavour_t flavour_of(input logic [AID_W-1:0] aid);
    flavour_t f;
    f = FLAV_UNKNOWN;
    if ((aid >= 5'd1) && (aid <= 5'd3)) begin
      f = FLAV_LIGHT;
    end else if (aid == GLUON_ID[AID_W-1:0]) begin
      f = FLAV_GLUON;
    end else if ((aid >= 5'd4) && (aid <= 5'd5)) begin
      f = FLAV_HEAVY;
    end
    return f;
  endfunction

endpackage

[rtl/jpfm_if.sv]
// interfaces: particle input channel and flavour tag output channel
interface jpfm_part_if import jpfm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [ETA_W-1:0] jet_eta;
  logic signed [PHI_W-1:0] jet_phi;
  logic [PT_W-1:0]         part_pt;
  logic signed [ETA_W-1:0] part_eta;
  logic signed [PHI_W-1:0] part_phi;
  logic signed [PID_W-1:0] part_id;
  logic                    first_item;
  logic                    last_item;

  modport source (
    output valid, jet_eta, jet_phi, part_pt, part_eta, part_phi, part_id,
           first_item, last_item,
    input  ready
  );
  modport sink (
    input  valid, jet_eta, jet_phi, part_pt, part_eta, part_phi, part_id,
           first_item, last_item,
    output ready
  );
endinterface

interface jpfm_tag_if import jpfm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        flavour;
  logic [AID_W-1:0]  leading_id;
  logic [PT_W-1:0]   leading_pt;

  modport source (
    output valid, flavour, leading_id, leading_pt,
    input  ready
  );
  modport sink (
    input  valid, flavour, leading_id, leading_pt,
    output ready
  );
endinterface

[rtl/jet_parton_flavour_match.sv]
// top level: jet flavour tag from the leading parton matched inside the jet cone
//
// Takes one generator particle per clock and produces one tag on each particle
// marked last_item; that particle passes the input and squared-distance registers
// before its tag is registered. The pipeline has three register levels: an input
// register holding the wrapped angle differences and the parton flag, a register
// holding the squared distance from the two 17x17 squarers, and the running best
// plus the tag register. The particle side stalls only when a last-particle transaction
// reaches the tag register while the previous tag has not been taken; otherwise the
// sustained rate is one particle per cycle. The user must write the cone radius
// register over the APB port only while no particle is in flight; the block does not enforce it.
module jet_parton_flavour_match import jpfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  jpfm_part_if.sink         particles,
  jpfm_tag_if.source        tags
);

  logic [RADIUS_W-1:0] match_radius_sq;
  logic                cfg_sel;

  logic                       s1_valid;
  logic signed [DIFF_W-1:0]   s1_deta;
  logic signed [DIFF_W-1:0]   s1_dphi;
  logic                       s1_parton;
  logic [AID_W-1:0]           s1_aid;
  logic [PT_W-1:0]            s1_pt;
  logic                       s1_first;
  logic                       s1_last;

  logic                       s2_valid;
  logic [DIST_W-1:0]          s2_dist;
  logic                       s2_parton;
  logic [AID_W-1:0]           s2_aid;
  logic [PT_W-1:0]            s2_pt;
  logic                       s2_first;
  logic                       s2_last;

  logic [PT_W-1:0]            best_pt;
  logic [AID_W-1:0]           best_id;
  logic [PT_W-1:0]            best_pt_next;
  logic [AID_W-1:0]           best_id_next;

  logic                       out_valid;
  flavour_t                   out_flavour;
  logic [AID_W-1:0]           out_id;
  logic [PT_W-1:0]            out_pt;

  logic                       adv;
  logic                       in_fire;
  logic                       done;
  logic [PID_W-1:0]           id_abs;
  logic signed [DIFF_W-1:0]   deta;
  logic signed [DIFF_W-1:0]   dphi_raw;
  logic signed [DIFF_W-1:0]   dphi;
  logic signed [2*DIFF_W-1:0] deta_prod;
  logic signed [2*DIFF_W-1:0] dphi_prod;
  logic [DIST_W-1:0]          cone_dist;
  logic [PT_W-1:0]            base_pt;
  logic [AID_W-1:0]           base_id;
  logic                       hit;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[APB_AW-1] == REG_MATCH_RADIUS_SQ);
  assign prdata  = cfg_sel ? APB_DW'(match_radius_sq) : '0;

  // handshake
  assign adv             = !(s2_valid && s2_last && out_valid && !tags.ready);
  assign particles.ready = adv;
  assign in_fire         = particles.valid && adv;
  assign done            = adv && s2_valid && s2_last;

  // first level: id magnitude and wrapped angle differences
  assign id_abs   = particles.part_id[PID_W-1] ? PID_W'(-particles.part_id)
                                               : PID_W'(particles.part_id);
  assign deta     = DIFF_W'(particles.jet_eta) - DIFF_W'(particles.part_eta);
  assign dphi_raw = DIFF_W'(particles.jet_phi) - DIFF_W'(particles.part_phi);

  always_comb begin
    dphi = dphi_raw;
    if (dphi_raw < -PI_Q12) begin
      dphi = dphi_raw + TWO_PI_Q12;
    end else if (dphi_raw > PI_Q12) begin
      dphi = dphi_raw - TWO_PI_Q12;
    end
  end

  // second level: squared distance
  assign deta_prod = s1_deta * s1_deta;
  assign dphi_prod = s1_dphi * s1_dphi;
  assign cone_dist = {1'b0, deta_prod[SQ_W-1:0]} + {1'b0, dphi_prod[SQ_W-1:0]};

  // third level: cone match and leading parton update
  assign base_pt = s2_first ? '0 : best_pt;
  assign base_id = s2_first ? '0 : best_id;
  assign hit     = s2_parton && (s2_dist <= DIST_W'(match_radius_sq)) && (s2_pt > base_pt);

  always_comb begin
    best_pt_next = hit ? s2_pt  : base_pt;
    best_id_next = hit ? s2_aid : base_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius_sq <= RADIUS_SQ_RESET;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
      best_pt         <= '0;
      best_id         <= '0;
    end else begin
      if (psel && penable && pwrite && cfg_sel) begin
        match_radius_sq <= pwdata[RADIUS_W-1:0];
      end
      if (adv) begin
        s1_valid <= in_fire;
        s2_valid <= s1_valid;
        if (s2_valid) begin
          if (s2_last) begin
            best_pt <= '0;
            best_id <= '0;
          end else begin
            best_pt <= best_pt_next;
            best_id <= best_id_next;
          end
        end
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (tags.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_deta   <= deta;
      s1_dphi   <= dphi;
      s1_parton <= is_parton(id_abs);
      s1_aid    <= id_abs[AID_W-1:0];
      s1_pt     <= particles.part_pt;
      s1_first  <= particles.first_item;
      s1_last   <= particles.last_item;
      s2_dist   <= cone_dist;
      s2_parton <= s1_parton;
      s2_aid    <= s1_aid;
      s2_pt     <= s1_pt;
      s2_first  <= s1_first;
      s2_last   <= s1_last;
    end
    if (done) begin
      out_flavour <= flavour_of(best_id_next);
      out_id      <= best_id_next;
      out_pt      <= best_pt_next;
    end
  end

  assign tags.valid      = out_valid;
  assign tags.flavour    = out_flavour;
  assign tags.leading_id = out_id;
  assign tags.leading_pt = out_pt;

`ifndef SYNTHESIS
  a_pt_id_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_pt == '0) == (out_id == '0)))
    else $error("leading pt and id disagree on an empty match");

  a_best_agree: assert property (@(posedge clk) disable iff (rst)
    (best_pt == '0) == (best_id == '0))
    else $error("running best pt and id disagree");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !particles.ready |-> (out_valid && !tags.ready && s2_valid && s2_last))
    else $error("particle side stalled without a blocked tag");

  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    done |=> (best_pt == '0) && out_valid)
    else $error("running best not cleared after a tag");
`endif

endmodule

[tb/flavour_tag_checker.sv]
// checker: predicts jet flavour tags from observed particle transactions and compares them
module flavour_tag_checker import jpfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  jpfm_part_if              parts,
  jpfm_tag_if               tags,
  output int unsigned       mismatches,
  output int unsigned       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIGHT_LO   = 1;
  localparam int LIGHT_HI   = 3;
  localparam int HEAVY_HI   = 5;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    flavour_t         flavour;
    logic [AID_W-1:0] leading_id;
    logic [PT_W-1:0]  leading_pt;
  } tag_t;

  tag_t                expected_tags[$];
  logic [RADIUS_W-1:0] cone_radius_sq;
  logic [PT_W-1:0]     lead_pt;
  logic [AID_W-1:0]    lead_id;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic flavour_t classify(input logic [AID_W-1:0] id);
    if (id >= LIGHT_LO && id <= LIGHT_HI) return FLAV_LIGHT;
    if (id > LIGHT_HI && id <= HEAVY_HI) return FLAV_HEAVY;
    if (id == GLUON_ID[AID_W-1:0]) return FLAV_GLUON;
    return FLAV_UNKNOWN;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t flavour tag mismatch: %s", $realtime, msg);
    end
  endtask

  // running leading parton, one tag per last particle
  task automatic track_particle();
    logic [PID_W-1:0] magnitude;
    int               d_eta;
    int               d_phi;
    longint           cone_dist;
    tag_t             want;
    if (parts.first_item) begin
      lead_pt = '0;
      lead_id = '0;
    end
    magnitude = parts.part_id;
    if (magnitude[PID_W-1]) magnitude = ~magnitude + 1'b1;
    if ((magnitude >= LIGHT_LO && magnitude <= HEAVY_HI) || magnitude == GLUON_ID) begin
      d_eta = int'(parts.jet_eta) - int'(parts.part_eta);
      d_phi = int'(parts.jet_phi) - int'(parts.part_phi);
      if (d_phi < -int'(PI_Q12)) d_phi += int'(TWO_PI_Q12);
      if (d_phi > int'(PI_Q12)) d_phi -= int'(TWO_PI_Q12);
      cone_dist = longint'(d_eta) * d_eta + longint'(d_phi) * d_phi;
      if (cone_dist <= longint'(cone_radius_sq) && parts.part_pt > lead_pt) begin
        lead_pt = parts.part_pt;
        lead_id = magnitude[AID_W-1:0];
      end
    end
    if (parts.last_item) begin
      want.flavour = classify(lead_id);
      want.leading_id = lead_id;
      want.leading_pt = lead_pt;
      expected_tags = {expected_tags, want};
      lead_pt = '0;
      lead_id = '0;
    end
  endtask

  task automatic check_tag();
    tag_t want;
    if (expected_tags.size() == 0) begin
      report($sformatf("unexpected tag flavour %0d id %0d pt %0d",
                       tags.flavour, tags.leading_id, tags.leading_pt));
      return;
    end
    want = expected_tags.pop_front();
    if (tags.flavour !== want.flavour || tags.leading_id !== want.leading_id ||
        tags.leading_pt !== want.leading_pt) begin
      report($sformatf("expected flavour %0d id %0d pt %0d, got flavour %0d id %0d pt %0d",
                       want.flavour, want.leading_id, want.leading_pt,
                       tags.flavour, tags.leading_id, tags.leading_pt));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cone_radius_sq = RADIUS_SQ_RESET;
      lead_pt = '0;
      lead_id = '0;
      expected_tags.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_MATCH_RADIUS_SQ, 2'b00}) begin
        cone_radius_sq = pwdata[RADIUS_W-1:0];
      end
      if (tags.valid && tags.ready) check_tag();
      if (parts.valid && parts.ready) track_particle();
    end
    pending = expected_tags.size();
  end

endmodule

[tb/jet_parton_flavour_match_test.sv]
// testbench top: particle stimulus, radius writes and verdict for jet_parton_flavour_match
module jet_parton_flavour_match_test import jpfm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 265;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          HOLD_CYCLES     = 400;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int          PARTON_IDS[6]   = '{1, 2, 3, 4, 5, 21};
  localparam int          PT_MAX          = 2**PT_W - 1;
  localparam int          RADIUS_MAX      = 2**RADIUS_W - 1;

  typedef struct {
    logic signed [ETA_W-1:0] jet_eta;
    logic signed [PHI_W-1:0] jet_phi;
    logic [PT_W-1:0]         part_pt;
    logic signed [ETA_W-1:0] part_eta;
    logic signed [PHI_W-1:0] part_phi;
    logic signed [PID_W-1:0] part_id;
    logic                    first_item;
    logic                    last_item;
  } particle_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       cycle_count = 0;
  int unsigned       send_gap_pct = 0;
  int unsigned       take_gap_pct = 0;
  int unsigned       hold_seq = 0;
  int unsigned       particles_sent = 0;

  jpfm_part_if parts();
  jpfm_tag_if  tags();

  jet_parton_flavour_match i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .particles (parts),
    .tags      (tags)
  );

  flavour_tag_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .parts      (parts),
    .tags       (tags),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("jet_parton_flavour_match_test: errors");
    $finish;
  end

  // tag receiver with random stalls and one long hold-off
  initial begin
    int unsigned hold_seen;
    int          hold_left;
    hold_seen = 0;
    hold_left = 0;
    tags.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        tags.ready <= 1'b0;
      end else begin
        tags.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  task automatic send_particle(input particle_t p);
    while ($urandom_range(99) < send_gap_pct) begin
      parts.valid <= 1'b0;
      @(negedge clk);
    end
    parts.valid <= 1'b1;
    parts.jet_eta <= p.jet_eta;
    parts.jet_phi <= p.jet_phi;
    parts.part_pt <= p.part_pt;
    parts.part_eta <= p.part_eta;
    parts.part_phi <= p.part_phi;
    parts.part_id <= p.part_id;
    parts.first_item <= p.first_item;
    parts.last_item <= p.last_item;
    do @(posedge clk); while (!parts.ready);
    particles_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(input int je, input int jp, input int pe, input int pp,
                             input int id, input int pt, input bit first, input bit last);
    particle_t p;
    p.jet_eta = je[ETA_W-1:0];
    p.jet_phi = jp[PHI_W-1:0];
    p.part_eta = pe[ETA_W-1:0];
    p.part_phi = pp[PHI_W-1:0];
    p.part_id = id;
    p.part_pt = pt[PT_W-1:0];
    p.first_item = first;
    p.last_item = last;
    send_particle(p);
  endtask

  // one jet of particles scattered around the jet axis, or a malformed one
  task automatic send_jet(input bit broken);
    particle_t               p;
    int                      count;
    int                      spread;
    int                      k;
    int                      e;
    int                      f;
    int                      pick;
    logic signed [ETA_W-1:0] jeta;
    logic signed [PHI_W-1:0] jphi;
    count = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
    spread = 1 << $urandom_range(14, 6);
    jeta = ETA_W'($urandom);
    f = int'($urandom_range(2 * int'(PI_Q12))) - int'(PI_Q12);
    jphi = f[PHI_W-1:0];
    for (k = 0; k < count; k++) begin
      p.jet_eta = jeta;
      p.jet_phi = jphi;
      e = int'(jeta) + int'($urandom_range(2 * spread)) - spread;
      p.part_eta = e[ETA_W-1:0];
      f = int'(jphi) + int'($urandom_range(2 * spread)) - spread;
      if (f > int'(PI_Q12)) f -= int'(TWO_PI_Q12);
      if (f < -int'(PI_Q12)) f += int'(TWO_PI_Q12);
      p.part_phi = f[PHI_W-1:0];
      if ($urandom_range(19) == 0) begin
        p.part_eta = ETA_W'($urandom);
        p.part_phi = PHI_W'($urandom);
      end
      pick = $urandom_range(9);
      if (pick < 8) begin
        p.part_id = PARTON_IDS[$urandom_range(5)];
      end else if (pick == 8) begin
        p.part_id = $urandom_range(30);
      end else begin
        p.part_id = $urandom;
      end
      if ($urandom_range(1)) p.part_id = -p.part_id;
      p.part_pt = PT_W'(($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(PT_MAX));
      p.first_item = (k == 0);
      p.last_item = (k == count - 1);
      if (broken) begin
        p.first_item = 1'($urandom_range(1));
        p.last_item = 1'($urandom_range(1));
        if ($urandom_range(1)) begin
          p.jet_eta = ETA_W'($urandom);
          p.jet_phi = PHI_W'($urandom);
        end
      end
      send_particle(p);
    end
  endtask

  task automatic drain();
    parts.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MATCH_RADIUS_SQ, 2'b00};
    pwdata <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int                  phase;
    int                  phase_end;
    logic [RADIUS_W-1:0] radius;
    parts.valid = 1'b0;
    parts.jet_eta = '0;
    parts.jet_phi = '0;
    parts.part_pt = '0;
    parts.part_eta = '0;
    parts.part_phi = '0;
    parts.part_id = '0;
    parts.first_item = 1'b0;
    parts.last_item = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_pct = 11;
    take_gap_pct = 76;
    // reset radius
    send_fields(0, 0, 0, 0, 1, PT_MAX, 1, 1);
    send_fields(32767, 0, -32768, 0, 21, 9, 1, 0);
    send_fields(32767, 0, 32767, 0, -5, 100, 0, 0);
    send_fields(32767, 0, 32767, 0, int'(32'h8000_0000), 1000, 0, 1);
    // azimuth wrap across pi and at the field limits
    send_fields(-32768, 12868, -32768, -12868, -21, 7, 1, 1);
    send_fields(0, -16384, 0, 16383, 2, 3, 1, 1);
    send_fields(0, 16383, 0, -16384, 2, 3, 1, 0);
    // zero pt never wins
    send_fields(0, 16383, 0, 16383, 3, 0, 0, 1);
    send_fields(0, 0, 0, 0, 22, 500, 1, 1);
    // non-parton ids and a pt tie
    send_fields(0, 0, 10, 10, 4, 10, 1, 0);
    send_fields(0, 0, 10, 10, 6, 20, 0, 0);
    send_fields(0, 0, 10, 10, -21, 30, 0, 0);
    send_fields(0, 0, 10, 10, 2, 30, 0, 0);
    send_fields(0, 0, 10, 10, 3, 25, 0, 1);
    // no first mark after a tag
    send_fields(0, 0, 0, 0, 2, 50, 0, 0);
    send_fields(0, 0, 0, 0, 21, 40, 0, 1);
    send_fields(0, 0, 0, 0, 0, 10, 1, 1);
    drain();
    // cone edge: distance equal to radius matches, one step out does not
    write_radius(26'd25000000);
    send_fields(0, 0, 3000, 4000, 1, 10, 1, 0);
    send_fields(0, 0, -3000, -4001, 4, 20, 0, 1);
    drain();
    write_radius('0);
    send_fields(100, 100, 100, 100, 21, 1, 1, 1);
    send_fields(100, 100, 101, 100, 5, 9, 1, 1);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_gap_pct = 11;
          take_gap_pct = 76;
        end
        1: begin
          send_gap_pct = 76;
          take_gap_pct = 11;
        end
        default: begin
          send_gap_pct = 0;
          take_gap_pct = 0;
        end
      endcase
      case (phase)
        0: radius = RADIUS_SQ_RESET;
        1: radius = '0;
        2: radius = RADIUS_W'(RADIUS_MAX);
        3: radius = 26'd16777216;
        default: radius = RADIUS_W'($urandom_range(RADIUS_MAX));
      endcase
      drain();
      write_radius(radius);
      if (phase == 4) hold_seq++;
      phase_end = particles_sent + ITEMS_PER_PHASE;
      while (particles_sent < phase_end) begin
        send_jet($urandom_range(99) < 15);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("jet_parton_flavour_match_test: clean");
    end else begin
      $display("jet_parton_flavour_match_test: errors");
    end
    $finish;
  end

endmodule
